/* rtl/core/tlf_pkg.sv */
// Package: payload types, widths and constants for the triangle frame core.
`timescale 1ns / 1ps
package tlf_pkg;

    localparam int unsigned VW = 24;   // vertex component width
    localparam int unsigned EW = 25;   // edge component width
    localparam int unsigned CW = 50;   // cross component width
    localparam int unsigned MW = 16;   // matrix element width
    localparam int unsigned UB = 15;   // normalized magnitude bits
    localparam int unsigned LW = 32;   // sum of squares width
    localparam int unsigned QB = 15;   // quotient bits, 0..16384
    localparam int unsigned RW = 64;   // root search residual width
    localparam int unsigned LAT = 21;  // length of the o_done valid shift register
    localparam logic signed [MW-1:0] ONE_Q14 = 16'sd16384;

    typedef struct packed {
        logic signed [VW-1:0] vertex_a_x;
        logic signed [VW-1:0] vertex_a_y;
        logic signed [VW-1:0] vertex_a_z;
        logic signed [VW-1:0] vertex_b_x;
        logic signed [VW-1:0] vertex_b_y;
        logic signed [VW-1:0] vertex_b_z;
        logic signed [VW-1:0] vertex_c_x;
        logic signed [VW-1:0] vertex_c_y;
        logic signed [VW-1:0] vertex_c_z;
    } t_tri_in;

    typedef struct packed {
        logic signed [MW-1:0] m_row0_col0;
        logic signed [MW-1:0] m_row0_col1;
        logic signed [MW-1:0] m_row0_col2;
        logic signed [MW-1:0] m_row1_col0;
        logic signed [MW-1:0] m_row1_col1;
        logic signed [MW-1:0] m_row1_col2;
        logic signed [MW-1:0] m_row2_col0;
        logic signed [MW-1:0] m_row2_col1;
        logic signed [MW-1:0] m_row2_col2;
        logic                 degenerate;
    } t_frame_out;

    // one vector after magnitude normalization
    typedef struct packed {
        logic [2:0]          neg;
        logic [2:0][UB-1:0]  mag;
        logic                zero;
    } t_nvec;

    // one vector in the root stage
    typedef struct packed {
        logic [2:0]          neg;
        logic [2:0][RW-1:0]  res;  // mag^2 * 2^30 - d^2 * L, two's complement
        logic [2:0][RW-1:0]  dl;   // d * L, two's complement
        logic [LW-1:0]       len2;
        logic [2:0][QB-1:0]  q;
        logic                zero;
    } t_rvec;

endpackage

/* rtl/core/tlf_norm.sv */
// Magnitude normalization of one vector: leading one search and shift, two stages.
`timescale 1ns / 1ps
module tlf_norm
    import tlf_pkg::*;
(
    input  logic                 i_clk,
    input  logic [2:0]           i_neg,
    input  logic [2:0][CW-1:0]   i_mag,
    output t_nvec                o_vec
);
    logic [CW-1:0] n_or;
    logic [5:0]    n_bits;
    logic [2:0][CW-1:0] r_mag;
    logic [2:0]    r_neg;
    logic [5:0]    r_bits;
    t_nvec         n_vec;

    always_comb begin
        n_or   = i_mag[0] | i_mag[1] | i_mag[2];
        n_bits = '0;
        for (int k = 0; k < CW; k++) begin
            if (n_or[k]) n_bits = 6'(k + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= i_mag;
        r_neg  <= i_neg;
        r_bits <= n_bits;
    end

    always_comb begin
        n_vec.neg  = r_neg;
        n_vec.zero = (r_bits == '0);
        for (int k = 0; k < 3; k++) begin
            if (r_bits > 6'(UB)) begin
                n_vec.mag[k] = UB'(r_mag[k] >> (r_bits - 6'(UB)));
            end else begin
                n_vec.mag[k] = UB'(r_mag[k] << (6'(UB) - r_bits));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_vec <= n_vec;
    end
endmodule

/* rtl/core/tlf_root.sv */
// Pipelined restoring search for round(c * 2^14 / sqrt(L)), one bit per stage.
`timescale 1ns / 1ps
module tlf_root
    import tlf_pkg::*;
(
    input  logic                  i_clk,
    input  t_nvec                 i_vec,
    output logic [2:0]            o_neg,
    output logic [2:0][QB-1:0]    o_q,
    output logic                  o_zero
);
    // stage 0: squares, length and starting residual (q = 0, d = -1)
    t_rvec r_st [0:QB];
    t_rvec n_st0;
    logic [2:0][2*UB-1:0] n_sq;

    always_comb begin
        n_st0.neg  = i_vec.neg;
        n_st0.zero = i_vec.zero;
        n_st0.q    = '0;
        n_st0.len2 = '0;
        for (int k = 0; k < 3; k++) begin
            n_sq[k]    = (2*UB)'(i_vec.mag[k] * i_vec.mag[k]);
            n_st0.len2 = n_st0.len2 + LW'(n_sq[k]);
        end
        for (int k = 0; k < 3; k++) begin
            n_st0.res[k] = RW'({n_sq[k], 30'd0}) - RW'(n_st0.len2);
            n_st0.dl[k]  = RW'(0) - RW'(n_st0.len2);
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[0] <= n_st0;
    end

    // bit B of the result: largest q with (2q-1)^2 * L <= mag^2 * 2^30.
    // Setting bit B moves d by 2^(B+1), so the new residual is
    // res - d*L*2^(B+2) - L*2^(2B+2): shifts and subtracts only.
    // Once bit 14 is set (q = 16384) no further bit may be added.
    for (genvar s = 0; s < QB; s++) begin : g_bit
        localparam int unsigned B = QB - 1 - s;
        t_rvec n_st;
        logic signed [RW-1:0] trial;
        always_comb begin
            n_st  = r_st[s];
            trial = '0;
            for (int k = 0; k < 3; k++) begin
                trial = $signed(r_st[s].res[k])
                      - ($signed(r_st[s].dl[k]) <<< (B + 2))
                      - $signed(RW'(r_st[s].len2) << (2 * B + 2));
                if (!r_st[s].q[k][QB-1] && !trial[RW-1]) begin
                    n_st.q[k]   = r_st[s].q[k] | QB'(1 << B);
                    n_st.res[k] = trial;
                    n_st.dl[k]  = r_st[s].dl[k] + (RW'(r_st[s].len2) << (B + 1));
                end
            end
        end
        always_ff @(posedge i_clk) begin
            r_st[s+1] <= n_st;
        end
    end

    assign o_neg  = r_st[QB].neg;
    assign o_q    = r_st[QB].q;
    assign o_zero = r_st[QB].zero;
endmodule

/* rtl/core/triangle_local_frame_core.sv */
// Top level of the triangle local frame core.
`timescale 1ns / 1ps
// Triangle local frame core. One triangle (beat) is taken per clock when
// start is high; busy is always low, since every stage advances every
// cycle and the receiver cannot stall. Each result appears for one cycle
// with o_done, after these stages in order: edges (1), cross products
// (2), leading-one normalize (2), squares (1), one result bit per stage
// through the root search (15). Throughput is one triangle per cycle,
// limited by nothing: the pipeline is fully pipelined. Degenerate edges or
// collinear triangles return the identity with o_result.degenerate set.
module triangle_local_frame_core
    import tlf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_tri_in     i_tri,
    output logic        o_done,
    output t_frame_out  o_result
);
    logic [LAT-1:0] r_vld;
    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];
    logic signed [2:0][CW-1:0] r_p1, r_p2;
    logic [2:0][CW-1:0] r_cm, r_m1, r_m2;
    logic [2:0] r_cn, r_n1, r_n2;
    logic signed [EW-1:0] r_e1b [3];
    logic signed [EW-1:0] r_e2b [3];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start};
        end
    end

    // stage 1: edges
    always_ff @(posedge i_clk) begin
        r_e1[0] <= EW'(i_tri.vertex_b_x) - EW'(i_tri.vertex_a_x);
        r_e1[1] <= EW'(i_tri.vertex_b_y) - EW'(i_tri.vertex_a_y);
        r_e1[2] <= EW'(i_tri.vertex_b_z) - EW'(i_tri.vertex_a_z);
        r_e2[0] <= EW'(i_tri.vertex_c_x) - EW'(i_tri.vertex_a_x);
        r_e2[1] <= EW'(i_tri.vertex_c_y) - EW'(i_tri.vertex_a_y);
        r_e2[2] <= EW'(i_tri.vertex_c_z) - EW'(i_tri.vertex_a_z);
    end

    // stage 2: products (25x25 signed), stage 3: cross differences
    always_ff @(posedge i_clk) begin
        r_p1[0] <= r_e1[1] * r_e2[2];
        r_p2[0] <= r_e1[2] * r_e2[1];
        r_p1[1] <= r_e1[2] * r_e2[0];
        r_p2[1] <= r_e1[0] * r_e2[2];
        r_p1[2] <= r_e1[0] * r_e2[1];
        r_p2[2] <= r_e1[1] * r_e2[0];
        r_e1b   <= r_e1;
        r_e2b   <= r_e2;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            logic signed [CW-1:0] c;
            c = r_p1[k] - r_p2[k];
            r_cn[k] <= c[CW-1];
            r_cm[k] <= c[CW-1] ? CW'(-c) : c;
            r_n1[k] <= r_e1b[k][EW-1];
            r_m1[k] <= r_e1b[k][EW-1] ? CW'(-r_e1b[k]) : CW'(r_e1b[k]);
            r_n2[k] <= r_e2b[k][EW-1];
            r_m2[k] <= r_e2b[k][EW-1] ? CW'(-r_e2b[k]) : CW'(r_e2b[k]);
        end
    end

    t_nvec w_v1, w_v2, w_vn;
    tlf_norm u_norm1 (.i_clk, .i_neg(r_n1), .i_mag(r_m1), .o_vec(w_v1));
    tlf_norm u_norm2 (.i_clk, .i_neg(r_n2), .i_mag(r_m2), .o_vec(w_v2));
    tlf_norm u_normn (.i_clk, .i_neg(r_cn), .i_mag(r_cm), .o_vec(w_vn));

    logic [2:0] w_g1, w_g2, w_gn;
    logic [2:0][QB-1:0] w_q1, w_q2, w_qn;
    logic w_z1, w_z2, w_zn;
    tlf_root u_root1 (.i_clk, .i_vec(w_v1), .o_neg(w_g1), .o_q(w_q1), .o_zero(w_z1));
    tlf_root u_root2 (.i_clk, .i_vec(w_v2), .o_neg(w_g2), .o_q(w_q2), .o_zero(w_z2));
    tlf_root u_rootn (.i_clk, .i_vec(w_vn), .o_neg(w_gn), .o_q(w_qn), .o_zero(w_zn));

    logic w_deg;
    logic signed [2:0][MW-1:0] w_c1, w_c2, w_cn;
    assign w_deg = w_z1 | w_z2 | w_zn;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_c1[k] = w_g1[k] ? -MW'(w_q1[k]) : MW'(w_q1[k]);
            w_c2[k] = w_g2[k] ? -MW'(w_q2[k]) : MW'(w_q2[k]);
            w_cn[k] = w_gn[k] ? -MW'(w_qn[k]) : MW'(w_qn[k]);
        end
        if (w_deg) begin
            w_c1 = '0; w_c2 = '0; w_cn = '0;
            w_c1[0] = ONE_Q14; w_c2[1] = ONE_Q14; w_cn[2] = ONE_Q14;
        end
    end

    assign o_done = r_vld[LAT-1];

    always_comb begin
        o_result.m_row0_col0 = w_c1[0];
        o_result.m_row0_col1 = w_c2[0];
        o_result.m_row0_col2 = w_cn[0];
        o_result.m_row1_col0 = w_c1[1];
        o_result.m_row1_col1 = w_c2[1];
        o_result.m_row1_col2 = w_cn[1];
        o_result.m_row2_col0 = w_c1[2];
        o_result.m_row2_col1 = w_c2[2];
        o_result.m_row2_col2 = w_cn[2];
        o_result.degenerate  = w_deg;
    end
endmodule

/* bench/triangle_local_frame_core_tb.sv */
// Testbench for the triangle local frame core: random and directed triangles vs. a frame predictor.
`timescale 1ns / 1ps
// Drives triangles through the start/busy command port and checks each
// o_done beat, field by field, against a predicted local frame computed
// here with exact integer arithmetic. Degenerate triangles (zero edges,
// collinear vertices) expect the identity. The block keeps no state, so
// there is no configuration phase.
module triangle_local_frame_core_tb;
    import tlf_pkg::*;

    localparam int CYCLE_CAP = 400000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_tri_in    i_tri = '0;
    logic       o_done;
    t_frame_out o_result;

    t_tri_in    tri_pending[$];   // triangles not yet issued
    t_frame_out frame_expected[$];
    int         error_count = 0;
    int         cycle_count = 0;
    int         gap_left = 0;
    bit         gaps_on = 1'b1;
    bit         hold_for_drain = 1'b0;
    bit         drain_done = 1'b0;
    bit         stim_done = 1'b0;

    triangle_local_frame_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_tri   (i_tri),
        .o_done  (o_done),
        .o_result(o_result)
    );

    always #2 i_clk = ~i_clk;

    // Unit scale of one integer vector in Q1.14; returns 0 for a zero vector.
    function automatic bit unit_scale(input longint v[3], output longint u[3]);
        longint unsigned mag[3];
        longint unsigned mx, len2, lo, hi, mid, d, rhs;
        int bits;
        mx = 0;
        len2 = 0;
        bits = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] > mx) mx = mag[i];
        end
        if (mx == 0) return 1'b0;
        while (bits < 63 && (mx >> bits) != 0) bits++;
        for (int i = 0; i < 3; i++) begin
            if (bits > 15) mag[i] = mag[i] >> (bits - 15);
            else mag[i] = mag[i] << (15 - bits);
            len2 += mag[i] * mag[i];
        end
        for (int i = 0; i < 3; i++) begin
            lo = 0;
            hi = 16384;
            rhs = (mag[i] * mag[i]) << 30;
            // round-half-away: largest q with (2q-1)^2 * len2 <= 4 c^2 2^28
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                d = 2 * mid - 1;
                if (d * d * len2 <= rhs) lo = mid;
                else hi = mid - 1;
            end
            u[i] = (v[i] < 0) ? -longint'(lo) : longint'(lo);
        end
        return 1'b1;
    endfunction

    function automatic t_frame_out predict_frame(input t_tri_in t);
        longint va[3], vb[3], vc[3], e1[3], e2[3], cr[3];
        longint u1[3], u2[3], un[3];
        bit ok;
        t_frame_out f;
        va = '{t.vertex_a_x, t.vertex_a_y, t.vertex_a_z};
        vb = '{t.vertex_b_x, t.vertex_b_y, t.vertex_b_z};
        vc = '{t.vertex_c_x, t.vertex_c_y, t.vertex_c_z};
        for (int i = 0; i < 3; i++) begin
            e1[i] = vb[i] - va[i];
            e2[i] = vc[i] - va[i];
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        ok = unit_scale(e1, u1);
        ok = unit_scale(e2, u2) && ok;
        ok = unit_scale(cr, un) && ok;
        if (!ok) begin
            u1 = '{16384, 0, 0};
            u2 = '{0, 16384, 0};
            un = '{0, 0, 16384};
        end
        f.m_row0_col0 = MW'(u1[0]); f.m_row0_col1 = MW'(u2[0]); f.m_row0_col2 = MW'(un[0]);
        f.m_row1_col0 = MW'(u1[1]); f.m_row1_col1 = MW'(u2[1]); f.m_row1_col2 = MW'(un[1]);
        f.m_row2_col0 = MW'(u1[2]); f.m_row2_col1 = MW'(u2[2]); f.m_row2_col2 = MW'(un[2]);
        f.degenerate = !ok;
        return f;
    endfunction

    function automatic logic [VW-1:0] rand_coord(input int kind);
        case (kind)
            0: return VW'($urandom);
            1: return VW'($urandom_range(0, 255) - 128);         // tiny coordinates
            default: return VW'($urandom_range(0, 65535) - 32768);
        endcase
    endfunction

    function automatic t_tri_in make_tri(input int ax, ay, az,
                                         bx, by, bz, cx, cy, cz);
        t_tri_in t;
        t = '{VW'(ax), VW'(ay), VW'(az), VW'(bx), VW'(by), VW'(bz),
              VW'(cx), VW'(cy), VW'(cz)};
        return t;
    endfunction

    // Fill the stimulus queue: directed corners first, then random triangles.
    initial begin
        logic [VW-1:0] mx, mn, p[9];
        int kind;
        mx = 24'h7FFFFF;
        mn = 24'h800000;
        tri_pending.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));     // all zero
        tri_pending.push_back(make_tri(0, 0, 0, 4096, 0, 0, 0, 4096, 0)); // unit xy
        tri_pending.push_back(make_tri(mn, mn, mn, mx, mx, mx, mx, mn, mx)); // extremes
        tri_pending.push_back(make_tri(mx, mx, mx, mn, mn, mn, mn, mx, mn));
        tri_pending.push_back(make_tri(mn, mx, mn, mx, mn, mx, mn, mn, mx));
        tri_pending.push_back(make_tri(1, 2, 3, 1, 2, 3, 9, 8, 7));     // first edge zero
        tri_pending.push_back(make_tri(1, 2, 3, 9, 8, 7, 1, 2, 3));     // edge from a to c zero
        tri_pending.push_back(make_tri(0, 0, 0, 1, 2, 3, 2, 4, 6));     // collinear
        tri_pending.push_back(make_tri(mn, mn, mn, 0, 0, 0, mx, mx, mx)); // collinear extremes
        tri_pending.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));     // smallest edges
        tri_pending.push_back(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0));
        tri_pending.push_back(make_tri(0, 0, 0, mx, 1, 0, mn, 0, 1));
        tri_pending.push_back(make_tri(5, 5, 5, 5, -3, 5, 5, 5, -7));   // negative axes
        tri_pending.push_back(make_tri(0, 0, 0, 3, 3, 3, 3, -3, 0));    // mixed-sign edges
        for (int n = 0; n < 1500; n++) begin
            kind = $urandom_range(0, 2);
            for (int i = 0; i < 9; i++) p[i] = rand_coord(kind);
            case ($urandom_range(0, 9))
                0: begin p[3] = p[0]; p[4] = p[1]; p[5] = p[2]; end  // zero edge
                1: for (int i = 0; i < 3; i++) p[6 + i] = VW'(2 * p[3 + i] - p[i]); // collinear
                default: ;
            endcase
            tri_pending.push_back(make_tri(p[0], p[1], p[2], p[3], p[4], p[5],
                                           p[6], p[7], p[8]));
        end
    end

    // Reset and cycle limit.
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Driver: issues one beat per accepted start, with random idle bursts.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                frame_expected.push_back(predict_frame(i_tri));
                void'(tri_pending.pop_front());
            end
            if (!start || !busy) begin
                if (tri_pending.size() == 700 && !drain_done) hold_for_drain = 1'b1;
                if (tri_pending.size() < 300) gaps_on = 1'b0;
                if (hold_for_drain) begin
                    // pause until every outstanding frame has come back
                    start <= 1'b0;
                    if (frame_expected.size() == 0) begin
                        hold_for_drain = 1'b0;
                        drain_done = 1'b1;
                    end
                end else if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    start <= 1'b0;
                end else if (gaps_on && $urandom_range(0, 19) == 0) begin
                    gap_left = $urandom_range(0, 15);
                    start <= 1'b0;
                end else if (tri_pending.size() != 0) begin
                    start <= 1'b1;
                    i_tri <= tri_pending[0];
                end else begin
                    start <= 1'b0;
                    stim_done = 1'b1;
                end
            end
        end
    end

    // Monitor: each o_done beat is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_frame_out exp_f;
        if (i_rst_n && o_done) begin
            if (frame_expected.size() == 0) begin
                $display("%0t: unexpected frame %h", $time, o_result);
                error_count++;
            end else begin
                exp_f = frame_expected.pop_front();
                if (o_result.m_row0_col0 !== exp_f.m_row0_col0)
                    $display("%0t: r0c0 exp %0d got %0d", $time, exp_f.m_row0_col0, o_result.m_row0_col0);
                if (o_result.m_row0_col1 !== exp_f.m_row0_col1)
                    $display("%0t: r0c1 exp %0d got %0d", $time, exp_f.m_row0_col1, o_result.m_row0_col1);
                if (o_result.m_row0_col2 !== exp_f.m_row0_col2)
                    $display("%0t: r0c2 exp %0d got %0d", $time, exp_f.m_row0_col2, o_result.m_row0_col2);
                if (o_result.m_row1_col0 !== exp_f.m_row1_col0)
                    $display("%0t: r1c0 exp %0d got %0d", $time, exp_f.m_row1_col0, o_result.m_row1_col0);
                if (o_result.m_row1_col1 !== exp_f.m_row1_col1)
                    $display("%0t: r1c1 exp %0d got %0d", $time, exp_f.m_row1_col1, o_result.m_row1_col1);
                if (o_result.m_row1_col2 !== exp_f.m_row1_col2)
                    $display("%0t: r1c2 exp %0d got %0d", $time, exp_f.m_row1_col2, o_result.m_row1_col2);
                if (o_result.m_row2_col0 !== exp_f.m_row2_col0)
                    $display("%0t: r2c0 exp %0d got %0d", $time, exp_f.m_row2_col0, o_result.m_row2_col0);
                if (o_result.m_row2_col1 !== exp_f.m_row2_col1)
                    $display("%0t: r2c1 exp %0d got %0d", $time, exp_f.m_row2_col1, o_result.m_row2_col1);
                if (o_result.m_row2_col2 !== exp_f.m_row2_col2)
                    $display("%0t: r2c2 exp %0d got %0d", $time, exp_f.m_row2_col2, o_result.m_row2_col2);
                if (o_result.degenerate !== exp_f.degenerate)
                    $display("%0t: degenerate exp %b got %b", $time, exp_f.degenerate, o_result.degenerate);
                if (o_result !== exp_f) error_count++;
            end
        end
    end

    // End of run: drain, then allow the pipeline depth for stray beats.
    initial begin
        wait (stim_done && frame_expected.size() == 0);
        repeat (LAT + 10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
